/* design/mmu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mmu_pkg;

  typedef enum logic [1:0] {
    MODE_ARITH,
    MODE_WEIGHT,
    MODE_GEO,
    MODE_HARM
  } mode_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_ZERO_DIV,
    ERR_GEO_SAMPLE,
    ERR_HARM_SAMPLE
  } err_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_PROD,
    S_WAIT,
    S_FINAL,
    S_FDIV,
    S_EXP,
    S_SHIFT,
    S_OUT
  } back_state_t;

  // one classified request as it travels from front to back
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] weight;
    logic               last;
    logic               accum;
    err_t               err;
    mode_t              mode;
  } item_t;

  localparam int unsigned STEP_W = 7;
  localparam logic [STEP_W-1:0] RECIP_STEPS = 7'd41;
  localparam logic [STEP_W-1:0] FULL_STEPS  = 7'd64;
  localparam logic [4:0] LOG_STEPS = 5'd16;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  // quotient magnitude with sign applied, clamped to 32 bits
  function automatic logic signed [31:0] sat32(input logic [63:0] q, input logic neg);
    logic [63:0] nq;
    nq = 64'd0 - q;
    if (!neg) begin
      return (q > 64'h7FFF_FFFF) ? S32_MAX : q[31:0];
    end
    return (q > 64'h8000_0000) ? S32_MIN : nq[31:0];
  endfunction

  // k+1 successive integer square roots starting from 2.0 in Q1.30
  function automatic logic [31:0] exp_root(input int k);
    logic [63:0] root, v, res, bt;
    int j, s;
    root = 64'd1 << 31;
    for (j = 0; j <= k; j++) begin
      v   = root << 30;
      res = 64'd0;
      bt  = 64'd1 << 62;
      for (s = 0; s < 32; s++) begin
        if (bt > v) bt = bt >> 2;
      end
      for (s = 0; s < 32; s++) begin
        if (bt != 64'd0) begin
          if (v >= res + bt) begin
            v   = v - (res + bt);
            res = (res >> 1) + bt;
          end else begin
            res = res >> 1;
          end
          bt = bt >> 2;
        end
      end
      root = res;
    end
    return root[31:0];
  endfunction

  localparam logic [31:0] EXP_ROOT [16] = '{
    exp_root(0),  exp_root(1),  exp_root(2),  exp_root(3),
    exp_root(4),  exp_root(5),  exp_root(6),  exp_root(7),
    exp_root(8),  exp_root(9),  exp_root(10), exp_root(11),
    exp_root(12), exp_root(13), exp_root(14), exp_root(15)
  };

endpackage

`default_nettype wire

/* design/mmu_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module mmu_div
  import mmu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [63:0]       num,
  input  wire logic [63:0]       den,
  input  wire logic [STEP_W-1:0] steps,
  output      logic              busy,
  output      logic [63:0]       quo
);

  logic [63:0]       rem;
  logic [63:0]       dvd;
  logic [63:0]       dsr;
  logic [STEP_W-1:0] cnt;
  logic [64:0]       trial;
  logic [64:0]       diff;
  logic              ge;

  // restoring, one quotient bit per cycle; only the low `steps` bits of num are used
  always_comb begin
    trial = {rem, dvd[63]};
    diff  = trial - {1'b0, dsr};
    ge    = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= steps;
      rem  <= '0;
      dvd  <= num << (FULL_STEPS - steps);
      dsr  <= den;
      quo  <= '0;
    end else if (busy) begin
      rem <= ge ? diff[63:0] : trial[63:0];
      dvd <= {dvd[62:0], 1'b0};
      quo <= {quo[62:0], ge};
      cnt <= cnt - 1'b1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/mmu_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module mmu_front
  import mmu_pkg::*;
#(
  parameter int unsigned MAX_COUNT = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_data,
  input  wire logic               sample_valid,
  output      logic               sample_stall,
  input  wire logic signed [31:0] sample_value,
  input  wire logic signed [31:0] sample_weight,
  input  wire logic               last_sample,
  input  wire logic               q_full,
  output      logic               q_push,
  output      item_t              q_item
);

  localparam int unsigned CW = $clog2(MAX_COUNT + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_COUNT);

  mode_t         mode;
  logic [CW-1:0] cnt;
  logic          accum;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ARITH;
    end else if (cfg_write) begin
      mode <= mode_t'(cfg_data);
    end
  end

  always_comb begin
    sample_stall = q_full;
    q_push       = sample_valid && !q_full;
    accum        = cnt < CNT_MAX;
    q_item.value  = sample_value;
    q_item.weight = sample_weight;
    q_item.last   = last_sample;
    q_item.accum  = accum;
    q_item.mode   = mode;
    q_item.err    = ERR_NONE;
    // samples past the run limit are not checked
    if (accum && mode == MODE_GEO && sample_value <= 32'sd0) begin
      q_item.err = ERR_GEO_SAMPLE;
    end else if (accum && mode == MODE_HARM && sample_value == 32'sd0) begin
      q_item.err = ERR_HARM_SAMPLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (q_push) begin
      if (last_sample) begin
        cnt <= '0;
      end else if (accum) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/mmu_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module mmu_fifo
  import mmu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output      logic  full,
  input  wire logic  pop,
  output      logic  valid,
  output      item_t head
);

  item_t       mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        do_push;
  logic        do_pop;

  always_comb begin
    full    = fill == 2'd2;
    valid   = fill != 2'd0;
    head    = mem[rd_ptr];
    do_push = push && !full;
    do_pop  = pop && valid;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/mmu_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module mmu_back
  import mmu_pkg::*;
#(
  parameter int unsigned MAX_COUNT = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire item_t              q_item,
  output      logic               q_pop,
  input  wire logic               mean_stall,
  output      logic               mean_valid,
  output      logic signed [31:0] mean_value,
  output      logic [10:0]        sample_count,
  output      logic [1:0]         error_code
);

  localparam int unsigned CW = $clog2(MAX_COUNT + 1);

  back_state_t state, state_next;
  item_t       e;
  logic [CW-1:0] cnt;
  err_t        err_seen;
  logic signed [63:0] value_sum, weighted_sum, weight_total, log_sum, recip_sum;
  logic signed [63:0] prod;
  logic [30:0] m;
  logic [4:0]  lp;
  logic [15:0] frac;
  logic [4:0]  lcnt;
  logic        neg;
  logic [15:0] ef;
  logic signed [15:0] ei;
  logic [31:0] r;
  logic [3:0]  ebit;
  logic signed [31:0] res_mean;
  err_t        res_err;

  // divider
  logic              div_start;
  logic [63:0]       div_num, div_den;
  logic [STEP_W-1:0] div_steps;
  logic              div_busy;
  logic [63:0]       div_quo;

  mmu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .steps (div_steps),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  logic signed [63:0] v64, w64, cnt64;
  logic [4:0]  lp_c;
  logic [30:0] m_init;
  logic signed [6:0]  ip;
  logic signed [63:0] log_val;
  logic signed [63:0] rq;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] sq_t;
  logic signed [31:0] q32;
  logic signed [16:0] sh;
  logic signed [16:0] nsh;
  logic signed [31:0] exp_val;
  logic [63:0] r_wide;
  logic        out_load;
  logic        fin_err1;
  logic signed [63:0] fin_num, fin_den;

  always_comb begin
    v64   = {{32{e.value[31]}}, e.value};
    w64   = {{32{e.weight[31]}}, e.weight};
    cnt64 = 64'(cnt);

    lp_c = '0;
    for (int k = 0; k < 31; k++) begin
      if (e.value[k]) lp_c = 5'(k);
    end
    m_init = e.value[30:0] << (5'd30 - lp_c);

    ip      = $signed({2'b00, lp}) - 7'sd16;
    log_val = {{41{ip[6]}}, ip, frac};
    rq      = e.value[31] ? $signed(64'd0 - div_quo) : $signed(div_quo);

    // one multiplier serves log squaring and exp root products
    if (state == S_EXP) begin
      mul_a = r;
      mul_b = EXP_ROOT[4'd15 - ebit];
    end else begin
      mul_a = {1'b0, m};
      mul_b = {1'b0, m};
    end
    mul_p = mul_a * mul_b;
    sq_t  = mul_p[61:30];

    q32 = sat32(div_quo, neg);

    sh     = {ei[15], ei} - 17'sd14;
    nsh    = 17'sd0 - sh;
    r_wide = {32'd0, r} >> nsh[5:0];
    if (!sh[16]) begin
      if (sh > 17'sd31 || r > (32'h7FFF_FFFF >> sh[4:0])) begin
        exp_val = S32_MAX;
      end else begin
        exp_val = r << sh[4:0];
      end
    end else if (nsh >= 17'sd63) begin
      exp_val = '0;
    end else begin
      exp_val = r_wide[31:0];
    end

    fin_err1 = 1'b0;
    fin_num  = value_sum;
    fin_den  = cnt64;
    case (e.mode)
      MODE_ARITH: begin
        fin_err1 = cnt == '0;
      end
      MODE_WEIGHT: begin
        fin_num  = weighted_sum;
        fin_den  = weight_total;
        fin_err1 = weight_total == 64'sd0;
      end
      MODE_GEO: begin
        fin_num  = log_sum;
        fin_err1 = cnt == '0;
      end
      MODE_HARM: begin
        fin_num  = cnt64 << 40;
        fin_den  = recip_sum;
        fin_err1 = recip_sum == 64'sd0;
      end
      default: ;
    endcase

    out_load = !mean_valid || !mean_stall;
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    div_num    = 64'd1 << 40;
    div_den    = mag64(v64);
    div_steps  = RECIP_STEPS;
    case (state)
      S_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          if (q_item.accum) state_next = S_ACC;
          else if (q_item.last) state_next = S_FINAL;
        end
      end
      S_ACC: begin
        div_start  = e.value != 32'sd0;
        state_next = S_PROD;
      end
      S_PROD: state_next = S_WAIT;
      S_WAIT: begin
        if (lcnt == 5'd0 && !div_busy) begin
          state_next = e.last ? S_FINAL : S_IDLE;
        end
      end
      S_FINAL: begin
        if (err_seen != ERR_NONE || fin_err1) begin
          state_next = S_OUT;
        end else begin
          div_start  = 1'b1;
          div_num    = mag64(fin_num);
          div_den    = mag64(fin_den);
          div_steps  = FULL_STEPS;
          state_next = S_FDIV;
        end
      end
      S_FDIV: begin
        if (!div_busy) state_next = (e.mode == MODE_GEO) ? S_EXP : S_OUT;
      end
      S_EXP: begin
        if (ebit == 4'd0) state_next = S_SHIFT;
      end
      S_SHIFT: state_next = S_OUT;
      S_OUT: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // log2 squaring loop runs beside the reciprocal division
  always_ff @(posedge clk) begin
    if (rst) begin
      lcnt <= '0;
    end else if (state == S_ACC && e.value > 32'sd0) begin
      lcnt <= LOG_STEPS;
      m    <= m_init;
      lp   <= lp_c;
      frac <= '0;
    end else if (lcnt != 5'd0) begin
      lcnt <= lcnt - 1'b1;
      m    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
      frac <= {frac[14:0], sq_t[31]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      err_seen     <= ERR_NONE;
      value_sum    <= '0;
      weighted_sum <= '0;
      weight_total <= '0;
      log_sum      <= '0;
      recip_sum    <= '0;
      mean_valid   <= 1'b0;
    end else begin
      if (mean_valid && !mean_stall && !(state == S_OUT && out_load)) begin
        mean_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) e <= q_item;
        end
        S_ACC: begin
          cnt          <= cnt + 1'b1;
          value_sum    <= sat_add(value_sum, v64);
          weight_total <= sat_add(weight_total, w64);
          prod         <= e.value * e.weight;
          if (err_seen == ERR_NONE) err_seen <= e.err;
        end
        S_PROD: begin
          weighted_sum <= sat_add(weighted_sum, prod);
        end
        S_WAIT: begin
          if (lcnt == 5'd0 && !div_busy) begin
            if (e.value > 32'sd0) log_sum <= sat_add(log_sum, log_val);
            if (e.value != 32'sd0) recip_sum <= sat_add(recip_sum, rq);
          end
        end
        S_FINAL: begin
          res_mean <= '0;
          neg      <= fin_num[63] ^ fin_den[63];
          if (err_seen != ERR_NONE) begin
            res_err <= err_seen;
          end else if (fin_err1) begin
            res_err <= ERR_ZERO_DIV;
          end else begin
            res_err <= ERR_NONE;
          end
        end
        S_FDIV: begin
          if (!div_busy) begin
            res_mean <= q32;
            ef       <= q32[15:0];
            ei       <= q32[31:16];
            r        <= 32'd1 << 30;
            ebit     <= 4'd15;
          end
        end
        S_EXP: begin
          if (ef[ebit]) r <= sq_t;
          ebit <= ebit - 1'b1;
        end
        S_SHIFT: begin
          res_mean <= exp_val;
        end
        S_OUT: begin
          if (out_load) begin
            mean_valid   <= 1'b1;
            mean_value   <= res_mean;
            sample_count <= 11'(cnt);
            error_code   <= res_err;
            cnt          <= '0;
            err_seen     <= ERR_NONE;
            value_sum    <= '0;
            weighted_sum <= '0;
            weight_total <= '0;
            log_sum      <= '0;
            recip_sum    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/four_mode_mean_unit.sv */
// channel   | handshake                 | payload
// ----------+---------------------------+------------------------------------------
// sample    | sample_valid/sample_stall | sample_value, sample_weight, last_sample
// mean      | mean_valid/mean_stall     | mean_value, sample_count, error_code
// config    | cfg_write                 | cfg_data (mean_mode)
//
// A nonzero sample holds the back end through the 41-step reciprocal
// division; a zero sample skips it. A last request adds setup, the output
// load and, unless the run has an error, a 64-step division, followed by
// exp2 in geometric mode; a stalled result holds the back end until it is taken.
// The front takes requests into a two-entry queue while the back is busy.
// Synchronous reset clears control state and accumulators.
`timescale 1ns / 1ps
`default_nettype none

module four_mode_mean_unit
  import mmu_pkg::*;
#(
  parameter int unsigned MAX_COUNT = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_data,
  input  wire logic               sample_valid,
  output      logic               sample_stall,
  input  wire logic signed [31:0] sample_value,
  input  wire logic signed [31:0] sample_weight,
  input  wire logic               last_sample,
  output      logic               mean_valid,
  input  wire logic               mean_stall,
  output      logic signed [31:0] mean_value,
  output      logic [10:0]        sample_count,
  output      logic [1:0]         error_code
);

  logic  q_full, q_push, q_pop, q_valid;
  item_t q_in, q_head;

  mmu_front #(.MAX_COUNT(MAX_COUNT)) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .sample_value  (sample_value),
    .sample_weight (sample_weight),
    .last_sample   (last_sample),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in)
  );

  mmu_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  mmu_back #(.MAX_COUNT(MAX_COUNT)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_head),
    .q_pop        (q_pop),
    .mean_stall   (mean_stall),
    .mean_valid   (mean_valid),
    .mean_value   (mean_value),
    .sample_count (sample_count),
    .error_code   (error_code)
  );

endmodule

`default_nettype wire

/* design/mmu_check.sv */
`timescale 1ns / 1ps
`default_nettype none

module mmu_check #(
  parameter int unsigned MAX_COUNT = 1024
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               mean_valid,
  input wire logic               mean_stall,
  input wire logic signed [31:0] mean_value,
  input wire logic [10:0]        sample_count,
  input wire logic [1:0]         error_code
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !mean_valid)
    else $error("result valid right after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    mean_valid && error_code != 2'd0 |-> mean_value == 32'sd0)
    else $error("errored run with nonzero mean");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    mean_valid |-> (MAX_COUNT > 2047 ||
                    (sample_count != 11'd0 && sample_count <= 11'(MAX_COUNT))))
    else $error("sample count out of range");

  // a run needs at least one request, so no result without an earlier accept
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    $rose(mean_valid) |-> !$past(rst))
    else $error("result raised straight out of reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    mean_valid && mean_stall |=> mean_valid && $stable(mean_value))
    else $error("stalled result changed");

endmodule

bind four_mode_mean_unit mmu_check #(.MAX_COUNT(MAX_COUNT)) u_check (.*);

`default_nettype wire

/* sim/mmu_mean_checker.sv */
`timescale 1ns / 1ps

module mmu_mean_checker
  import mmu_pkg::*;
#(
  parameter int unsigned MAX_COUNT = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_data,
  input  logic               sample_valid,
  input  logic               sample_stall,
  input  logic signed [31:0] sample_value,
  input  logic signed [31:0] sample_weight,
  input  logic               last_sample,
  input  logic               mean_valid,
  input  logic               mean_stall,
  input  logic signed [31:0] mean_value,
  input  logic [10:0]        sample_count,
  input  logic [1:0]         error_code,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic signed [31:0] mean;
    logic [10:0]        count;
    err_t               err;
  } mean_result_t;

  mean_result_t mean_q[$];

  mode_t              cur_mode;
  logic signed [63:0] sum_v, sum_vw, sum_w, sum_log, sum_recip;
  int unsigned        run_len;
  err_t               run_err;

  function automatic logic signed [63:0] add_clamp(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    return s[63:0];
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] x);
    return x < 0 ? 64'd0 - x : x;
  endfunction

  // truncating divide, quotient clamped to 32 bits
  function automatic logic signed [31:0] div_clamp(input logic signed [63:0] num,
                                                   input logic signed [63:0] den);
    logic [63:0] q;
    logic        neg;
    q = abs64(num) / abs64(den);
    neg = (num < 0) != (den < 0);
    if (!neg) return q > 64'h7FFF_FFFF ? 32'sh7FFF_FFFF : q[31:0];
    if (q > 64'h8000_0000) return 32'sh8000_0000;
    return -q[31:0];
  endfunction

  function automatic logic signed [63:0] log2_fix(input logic [31:0] x);
    int          p, k;
    logic [63:0] m;
    logic [63:0] frac;
    p = 0;
    frac = 0;
    for (k = 0; k < 32; k++) if (x[k]) p = k;
    m = (p <= 30) ? (64'(x) << (30 - p)) : (64'(x) >> (p - 30));
    for (k = 0; k < 16; k++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return 64'(signed'(p - 16)) * 65536 + signed'(frac);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] exp2_fix(input logic signed [31:0] y);
    logic [15:0] f;
    int          ip, sh, b;
    logic [63:0] root, r;
    f = y[15:0];
    ip = int'(y >>> 16);
    root = 64'd1 << 31;
    r = 64'd1 << 30;
    for (b = 15; b >= 0; b--) begin
      root = int_sqrt(root << 30);
      if (f[b]) r = (r * root) >> 30;
    end
    sh = ip - 14;
    if (sh >= 0) begin
      if (sh > 31 || r > (64'h7FFF_FFFF >> sh)) return 32'sh7FFF_FFFF;
      return 32'(r << sh);
    end
    if (-sh >= 63) return 0;
    return 32'(r >> (-sh));
  endfunction

  function automatic void clear_run();
    sum_v = 0;
    sum_vw = 0;
    sum_w = 0;
    sum_log = 0;
    sum_recip = 0;
    run_len = 0;
    run_err = ERR_NONE;
  endfunction

  function automatic void absorb_sample(input logic signed [31:0] v,
                                        input logic signed [31:0] w,
                                        input logic last);
    mean_result_t       res;
    logic signed [63:0] v64, rq;
    v64 = v;
    if (run_len < MAX_COUNT) begin
      run_len++;
      sum_v = add_clamp(sum_v, v64);
      sum_vw = add_clamp(sum_vw, v64 * 64'(w));
      sum_w = add_clamp(sum_w, 64'(w));
      if (v > 0) sum_log = add_clamp(sum_log, log2_fix(v));
      if (v != 0) begin
        rq = signed'((64'd1 << 40) / abs64(v64));
        sum_recip = add_clamp(sum_recip, v < 0 ? -rq : rq);
      end
      if (run_err == ERR_NONE) begin
        if (cur_mode == MODE_GEO && v <= 0) run_err = ERR_GEO_SAMPLE;
        else if (cur_mode == MODE_HARM && v == 0) run_err = ERR_HARM_SAMPLE;
      end
    end
    if (!last) return;
    res.err = run_err;
    res.mean = 0;
    res.count = 11'(run_len);
    if (res.err == ERR_NONE) begin
      case (cur_mode)
        MODE_ARITH: begin
          if (run_len == 0) res.err = ERR_ZERO_DIV;
          else res.mean = div_clamp(sum_v, 64'(run_len));
        end
        MODE_WEIGHT: begin
          if (sum_w == 0) res.err = ERR_ZERO_DIV;
          else res.mean = div_clamp(sum_vw, sum_w);
        end
        MODE_GEO: begin
          if (run_len == 0) res.err = ERR_ZERO_DIV;
          else res.mean = exp2_fix(div_clamp(sum_log, 64'(run_len)));
        end
        default: begin
          if (sum_recip == 0) res.err = ERR_ZERO_DIV;
          else res.mean = div_clamp(64'(run_len) << 40, sum_recip);
        end
      endcase
    end
    if (res.err != ERR_NONE) res.mean = 0;
    mean_q.push_back(res);
    clear_run();
  endfunction

  always @(posedge clk) begin
    mean_result_t want;
    if (rst) begin
      cur_mode = MODE_ARITH;
      clear_run();
      mean_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_write) cur_mode = mode_t'(cfg_data);
      if (sample_valid && !sample_stall) absorb_sample(sample_value, sample_weight, last_sample);
      if (mean_valid && !mean_stall) begin
        if (mean_q.size() == 0) begin
          $error("unexpected mean result: value %0d count %0d error %0d",
                 mean_value, sample_count, error_code);
          fail_count++;
        end else begin
          want = mean_q.pop_front();
          if (mean_value !== want.mean) begin
            $error("mean_value: expected %0d, got %0d", want.mean, mean_value);
            fail_count++;
          end
          if (sample_count !== want.count) begin
            $error("sample_count: expected %0d, got %0d", want.count, sample_count);
            fail_count++;
          end
          if (error_code !== want.err) begin
            $error("error_code: expected %0d, got %0d", want.err, error_code);
            fail_count++;
          end
        end
      end
    end
    pending = mean_q.size();
  end

endmodule

/* sim/tb_four_mode_mean_unit.sv */
`timescale 1ns / 1ps

module tb_four_mode_mean_unit;
  import mmu_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 400;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_data = '0;
  logic               sample_valid = 1'b0;
  logic               sample_stall;
  logic signed [31:0] sample_value = '0;
  logic signed [31:0] sample_weight = '0;
  logic               last_sample = 1'b0;
  logic               mean_valid;
  logic               mean_stall = 1'b0;
  logic signed [31:0] mean_value;
  logic [10:0]        sample_count;
  logic [1:0]         error_code;
  int                 fail_count;
  int                 pending;
  logic               send_busy = 1'b1;
  logic               recv_busy = 1'b1;
  int                 idle_cycles = 0;

  always #5 clk = ~clk;

  four_mode_mean_unit i_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .sample_value(sample_value), .sample_weight(sample_weight),
    .last_sample(last_sample), .mean_valid(mean_valid), .mean_stall(mean_stall),
    .mean_value(mean_value), .sample_count(sample_count), .error_code(error_code)
  );

  mmu_mean_checker i_checker (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .sample_value(sample_value), .sample_weight(sample_weight),
    .last_sample(last_sample), .mean_valid(mean_valid), .mean_stall(mean_stall),
    .mean_value(mean_value), .sample_count(sample_count), .error_code(error_code),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (mean_valid && !mean_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // result side: random stall before each result is taken while recv_busy is set
  initial begin
    int k;
    @(negedge rst);
    forever begin
      k = recv_busy ? $urandom_range(0, 13) : 0;
      if (k > 0) begin
        mean_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      mean_stall <= 1'b0;
      @(posedge clk);
      while (!mean_valid) @(posedge clk);
    end
  end

  // valid is left high after acceptance; a gap in the next call or pause_sender lowers it
  task automatic send_sample(input logic signed [31:0] v, input logic signed [31:0] w,
                             input logic last);
    int gap;
    gap = send_busy ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_value <= v;
    sample_weight <= w;
    last_sample <= last;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  // drain every result, then let a run with no result finish in the back end
  task automatic pause_sender();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input mode_t m);
    pause_sender();
    cfg_write <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic signed [31:0] draw_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3, 4:    return $urandom_range(1, 32'h003F_FFFF);
      5:       return $urandom_range(32'h7000_0000, 32'h7FFF_FFFF);
      6:       return 0;
      7:       return -$signed($urandom_range(1, 32'h00FF_FFFF));
      8:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $urandom_range(1, 32'h0010_0000);
    endcase
  endfunction

  initial begin
    int n, len, i;
    logic signed [31:0] v;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: arithmetic extremes
    send_sample(32'sh7FFF_FFFF, 0, 1'b1);
    send_sample(32'sh8000_0000, 1, 1'b0);
    send_sample(32'sh8000_0000, -1, 1'b1);
    // weighted: normal, zero weight total, extreme products
    set_mode(MODE_WEIGHT);
    send_sample(32'sh0003_0000, 32'sh0001_0000, 1'b0);
    send_sample(32'sh0001_0000, 32'sh0002_0000, 1'b1);
    send_sample(32'sh0001_0000, 32'sh0001_0000, 1'b0);
    send_sample(32'sh0005_0000, -32'sh0001_0000, 1'b1);
    send_sample(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    // geometric: ones, maximum, tiny, zero and negative samples
    set_mode(MODE_GEO);
    send_sample(32'sh0001_0000, 0, 1'b0);
    send_sample(32'sh0004_0000, 0, 1'b1);
    send_sample(32'sh7FFF_FFFF, 0, 1'b1);
    send_sample(1, 0, 1'b1);
    send_sample(0, 0, 1'b1);
    send_sample(32'sh0002_0000, 0, 1'b0);
    send_sample(32'sh8000_0000, 0, 1'b1);
    // harmonic: zero sample, reciprocals that cancel, extremes
    set_mode(MODE_HARM);
    send_sample(0, 0, 1'b1);
    send_sample(32'sh0002_0000, 0, 1'b0);
    send_sample(-32'sh0002_0000, 0, 1'b1);
    send_sample(32'sh7FFF_FFFF, 0, 1'b0);
    send_sample(1, 0, 1'b1);
    // mode change inside a run: error kept from the geometric part
    set_mode(MODE_ARITH);
    send_sample(32'sh0001_0000, 0, 1'b0);
    set_mode(MODE_GEO);
    send_sample(0, 0, 1'b0);
    set_mode(MODE_ARITH);
    send_sample(32'sh0003_0000, 0, 1'b1);

    // run longer than the sample limit
    send_busy = 1'b0;
    recv_busy = 1'b0;
    for (i = 0; i < 1030; i++) send_sample($urandom_range(0, 32'h0001_FFFF), 0, i == 1029);

    n = 0;
    while (n < 800) begin
      if ($urandom_range(0, 7) == 0) set_mode(mode_t'($urandom_range(0, 3)));
      if ($urandom_range(0, 5) == 0) begin
        send_busy = $urandom_range(0, 3) != 0;
        recv_busy = $urandom_range(0, 3) != 0;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (i = 0; i < len; i++) begin
        v = draw_value();
        send_sample(v, $urandom_range(0, 4) == 0 ? draw_value() : $urandom(), i == len - 1);
        // occasional mode switch while a run is open
        if (i != len - 1 && $urandom_range(0, 60) == 0) set_mode(mode_t'($urandom_range(0, 3)));
        n++;
      end
    end

    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
